FILE: design/kdeg_pkg.sv
// Shared types, constants and codes for the key debounce event generator.
`timescale 1ns / 1ps

package kdeg_pkg;

	localparam int KEY_W = 6;
	localparam int EVT_W = 8;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int TIMER_WIDTH_DEF = 16;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] HOLD_RST = 16'd1000;

	localparam logic [EVT_W-1:0] FLAG_REL = 8'h40;
	localparam logic [EVT_W-1:0] FLAG_HOLD = 8'h80;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_READ = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 1'b0,
		REG_HOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_DONE = 2'd0,
		PH_NEW = 2'd1,
		PH_PRESS = 2'd2
	} phase_t;

	typedef struct packed {
		logic opcode;
		logic [KEY_W-1:0] raw_key;
	} item_t;

	typedef struct packed {
		logic valid;
		logic [EVT_W-1:0] code;
	} result_t;

endpackage

FILE: design/kdeg_in_stage.sv
// Input register stage: holds one accepted transaction until the core takes it.
`timescale 1ns / 1ps

module kdeg_in_stage (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic opcode,
	input logic [kdeg_pkg::KEY_W-1:0] raw_key,
	input logic advance,
	output logic item_valid,
	output kdeg_pkg::item_t item
);
	import kdeg_pkg::*;

	logic valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || advance;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.opcode <= opcode;
			item_s1.raw_key <= raw_key;
		end
	end

endmodule

FILE: design/kdeg_core.sv
// Debounce state, timer, configuration registers and per-item update logic.
`timescale 1ns / 1ps

module kdeg_core #(
	parameter int TIMER_WIDTH = kdeg_pkg::TIMER_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [kdeg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [kdeg_pkg::CFG_W-1:0] cfg_data,
	input logic item_valid,
	input kdeg_pkg::item_t item,
	input logic out_free,
	output logic advance,
	output kdeg_pkg::result_t result
);
	import kdeg_pkg::*;

	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] hold_q;
	phase_t phase_q;
	phase_t phase_d;
	logic [KEY_W-1:0] prev_key_q;
	logic [EVT_W-1:0] cur_event_q;
	logic [EVT_W-1:0] cur_event_d;
	logic [EVT_W-1:0] last_rep_q;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic [TIMER_WIDTH-1:0] timer_dec;
	logic [TIMER_WIDTH-1:0] timer_d;
	logic is_read;
	logic is_tick;

	// Load value for the timer, saturated when the register does not fit.
	function automatic logic [TIMER_WIDTH-1:0] start_value(input logic [CFG_W-1:0] ticks);
		logic [TIMER_WIDTH-1:0] v;
		if (TIMER_WIDTH < CFG_W && (ticks >> TIMER_WIDTH) != '0) begin
			v = '1;
		end else begin
			v = TIMER_WIDTH'(ticks);
		end
		return v;
	endfunction

	assign is_read = (item.opcode == OP_READ);
	// A tick never produces a result, so it can proceed even when the output is full.
	assign advance = item_valid && (!is_read || out_free);
	assign is_tick = advance && !is_read;

	assign timer_dec = (timer_q != '0) ? timer_q - 1'b1 : timer_q;

	always_comb begin
		phase_d = phase_q;
		cur_event_d = cur_event_q;
		timer_d = timer_dec;
		if (item.raw_key != prev_key_q) begin
			timer_d = start_value(debounce_q);
			phase_d = PH_NEW;
		end else if (timer_dec == '0) begin
			unique case (phase_q)
				PH_NEW: begin
					if (item.raw_key != '0) begin
						if ((cur_event_q & FLAG_REL) == '0) begin
							cur_event_d = (cur_event_q & ~FLAG_HOLD) | FLAG_REL;
							timer_d = start_value(debounce_q);
						end else begin
							cur_event_d = EVT_W'(item.raw_key);
							timer_d = start_value(hold_q);
							phase_d = PH_PRESS;
						end
					end else begin
						cur_event_d = (cur_event_q & ~FLAG_HOLD) | FLAG_REL;
						phase_d = PH_DONE;
					end
				end
				PH_PRESS: begin
					cur_event_d = cur_event_q | FLAG_HOLD;
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			hold_q <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_HOLD: hold_q <= cfg_data;
				default: debounce_q <= debounce_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			prev_key_q <= '0;
			cur_event_q <= '0;
			last_rep_q <= '0;
			timer_q <= '0;
		end else if (is_tick) begin
			phase_q <= phase_d;
			prev_key_q <= item.raw_key;
			cur_event_q <= cur_event_d;
			timer_q <= timer_d;
		end else if (advance && last_rep_q != cur_event_q) begin
			last_rep_q <= cur_event_q;
		end
	end

	assign result.valid = advance && is_read;
	assign result.code = (last_rep_q != cur_event_q) ? cur_event_q : '0;

endmodule

FILE: design/kdeg_out_stage.sv
// Output register: holds one result until the consumer takes it.
`timescale 1ns / 1ps

module kdeg_out_stage (
	input logic clk,
	input logic arst_n,
	input kdeg_pkg::result_t result,
	output logic out_free,
	output logic out_valid,
	input logic out_ready,
	output logic [kdeg_pkg::EVT_W-1:0] event_code
);
	import kdeg_pkg::*;

	logic valid_q;
	logic [EVT_W-1:0] code_q;

	assign out_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign event_code = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && result.valid) begin
			code_q <= result.code;
		end
	end

endmodule

FILE: design/key_debounce_event_generator_top.sv
// Top level of the key debounce event generator.
//
//   Channel  Handshake              Payload
//   in       in_valid / in_ready    opcode, raw_key
//   out      out_valid / out_ready  event_code
//   cfg      cfg_we                 cfg_index, cfg_data
//
// One transaction per cycle while no read is stalled: input register, combinational update logic, output register.
// A read's result passes the input register and then the output register; a tick produces no result.
// Reset clears the valid flags and the debounce state and loads debounce 50 and hold 1000 ticks.
// A read stalls in the input register only while the output register is full and not taken.
`timescale 1ns / 1ps

module key_debounce_event_generator_top #(
	parameter int TIMER_WIDTH = kdeg_pkg::TIMER_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [kdeg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [kdeg_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic opcode,
	input logic [kdeg_pkg::KEY_W-1:0] raw_key,
	output logic out_valid,
	input logic out_ready,
	output logic [kdeg_pkg::EVT_W-1:0] event_code
);
	import kdeg_pkg::*;

	logic advance;
	logic item_valid;
	item_t item;
	logic out_free;
	result_t result;

	kdeg_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.raw_key(raw_key),
		.advance(advance),
		.item_valid(item_valid),
		.item(item)
	);

	kdeg_core #(
		.TIMER_WIDTH(TIMER_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item(item),
		.out_free(out_free),
		.advance(advance),
		.result(result)
	);

	kdeg_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.result(result),
		.out_free(out_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_code(event_code)
	);

	// An empty input register always takes a new transaction.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!item_valid |-> in_ready)
		else $error("input stage empty but not ready");

	// A read held behind a full, stalled output register blocks the input.
	a_read_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item.opcode == OP_READ && out_valid && !out_ready) |-> !in_ready)
		else $error("read advanced into a full output register");

	// Only reads produce results.
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (item_valid && item.opcode == OP_READ))
		else $error("result produced by a tick");

endmodule

FILE: verif/key_debounce_event_generator_top_tb.sv
// Self-checking testbench for the key debounce event generator top level.
`timescale 1ns / 1ps

module key_debounce_event_generator_top_tb;
	import kdeg_pkg::*;

	localparam int IDLE_PCT = 15;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_TICK;
	logic [KEY_W-1:0] raw_key = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [EVT_W-1:0] event_code;

	key_debounce_event_generator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.raw_key(raw_key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_code(event_code)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted state of the debouncer.
	logic [CFG_W-1:0] debounce_len = DEBOUNCE_RST;
	logic [CFG_W-1:0] hold_len = HOLD_RST;
	phase_t key_phase = PH_DONE;
	logic [KEY_W-1:0] last_key = '0;
	logic [EVT_W-1:0] held_event = '0;
	logic [EVT_W-1:0] reported_event = '0;
	logic [CFG_W-1:0] countdown = '0;

	item_t key_items[$];
	logic [EVT_W-1:0] event_codes_due[$];

	int items_queued = 0;
	int items_accepted = 0;
	int reads_checked = 0;
	int mismatches = 0;
	int settings_used = 0;
	int release_events = 0;
	int hold_events = 0;
	int quiet_cycles = 0;
	int hold_off_left = HOLD_OFF_CYCLES;
	bit steady_flow = 1'b0;
	bit hold_off_phase = 1'b0;

	// The timer is as wide as the registers, so a start never saturates.
	function automatic void advance_debouncer(input logic op, input logic [KEY_W-1:0] key);
		logic [EVT_W-1:0] code;
		if (opcode_t'(op) == OP_READ) begin
			code = '0;
			if (reported_event != held_event) begin
				reported_event = held_event;
				code = held_event;
			end
			event_codes_due.push_back(code);
		end else begin
			if (countdown != '0)
				countdown = countdown - 1'b1;
			if (key != last_key) begin
				countdown = debounce_len;
				last_key = key;
				key_phase = PH_NEW;
			end else if ((key_phase == PH_NEW || key_phase == PH_PRESS) && countdown == '0) begin
				if (key_phase == PH_PRESS) begin
					held_event = held_event | FLAG_HOLD;
					key_phase = PH_DONE;
				end else if (key == '0) begin
					held_event = (held_event & ~FLAG_HOLD) | FLAG_REL;
					key_phase = PH_DONE;
				end else if ((held_event & FLAG_REL) == '0) begin
					// A press without a preceding release gets one first, plus a guard wait.
					held_event = (held_event & ~FLAG_HOLD) | FLAG_REL;
					countdown = debounce_len;
				end else begin
					held_event = {2'b00, key};
					countdown = hold_len;
					key_phase = PH_PRESS;
				end
			end
		end
	endfunction

	// Sender: offers queued items and updates the prediction on each accepted transaction.
	always @(posedge clk) begin
		item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				advance_debouncer(opcode, raw_key);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (key_items.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = key_items.pop_front();
					in_valid <= 1'b1;
					opcode <= nxt.opcode;
					raw_key <= nxt.raw_key;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result transaction against the oldest predicted event code.
	always @(posedge clk) begin
		logic [EVT_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_off_left = HOLD_OFF_CYCLES;
		end else begin
			if (out_valid && out_ready) begin
				if (event_codes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("Unexpected result: got %02h with nothing pending", event_code);
				end else begin
					want = event_codes_due.pop_front();
					reads_checked++;
					if (event_code !== want) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("Mismatch on read %0d: expected %02h, got %02h",
								reads_checked, want, event_code);
					end
					if ((want & FLAG_REL) != '0)
						release_events++;
					if ((want & FLAG_HOLD) != '0)
						hold_events++;
				end
			end
			if (hold_off_phase && hold_off_left != 0) begin
				hold_off_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic queue_item(input opcode_t op, input logic [KEY_W-1:0] key);
		item_t it;
		it.opcode = op;
		it.raw_key = key;
		key_items.push_back(it);
		items_queued++;
	endtask

	// Holds one raw code for a number of ticks, with reads mixed in.
	task automatic queue_key_run(input logic [KEY_W-1:0] key, input int ticks);
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(99) < 20)
				queue_item(OP_READ, KEY_W'($urandom()));
			queue_item(OP_TICK, key);
		end
	endtask

	// Waits until the block is idle, then lets the pipeline empty.
	task automatic settle();
		do
			@(negedge clk);
		while (key_items.size() != 0 || in_valid || event_codes_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEBOUNCE)
			debounce_len = val;
		else
			hold_len = val;
	endtask

	task automatic run_phase(input int deb, input int hold, input int n_items,
		input bit calm, input bit stall);
		int start;
		int press_max;
		int release_max;
		int kind;
		settle();
		write_register(REG_DEBOUNCE, CFG_W'(deb));
		write_register(REG_HOLD, CFG_W'(hold));
		settings_used++;
		steady_flow = calm;
		hold_off_phase = stall;
		// Runs long enough to reach a hold, capped so that slow settings stay short.
		press_max = (2 * deb + hold + 3 > 120) ? 120 : 2 * deb + hold + 3;
		release_max = (deb + 3 > 40) ? 40 : deb + 3;
		start = items_queued;
		while (items_queued - start < n_items) begin
			kind = $urandom_range(9);
			if (kind < 7) begin
				queue_key_run(KEY_W'($urandom_range(63, 1)), $urandom_range(press_max, 1));
				queue_key_run('0, $urandom_range(release_max, 1));
			end else if (kind < 9) begin
				repeat ($urandom_range(8, 1))
					queue_key_run(KEY_W'($urandom_range(63)), $urandom_range(3, 1));
			end else begin
				queue_item(OP_READ, KEY_W'($urandom()));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: nothing settles within a few ticks, so every read returns zero.
		queue_item(OP_READ, '0);
		queue_item(OP_TICK, 6'h3f);
		queue_item(OP_TICK, 6'h3f);
		queue_item(OP_READ, 6'h3f);
		queue_item(OP_TICK, '0);
		queue_item(OP_READ, 6'h2a);
		settle();

		// Zero registers expire the timer on the very next tick.
		write_register(REG_DEBOUNCE, '0);
		write_register(REG_HOLD, '0);
		settings_used++;
		queue_item(OP_TICK, 6'h01);
		queue_item(OP_TICK, 6'h01);
		queue_item(OP_READ, '0);
		queue_item(OP_TICK, 6'h01);
		queue_item(OP_READ, 6'h15);
		queue_item(OP_TICK, 6'h01);
		queue_item(OP_READ, '0);
		queue_item(OP_READ, 6'h3f);
		queue_item(OP_TICK, 6'h3f);
		queue_item(OP_TICK, 6'h3f);
		queue_item(OP_TICK, 6'h3f);
		queue_item(OP_READ, '0);
		queue_item(OP_TICK, '0);
		queue_item(OP_TICK, '0);
		queue_item(OP_READ, '0);

		run_phase(1, 1, 150, 1'b0, 1'b0);
		run_phase(2, 5, 150, 1'b1, 1'b0);
		run_phase(3, 12, 150, 1'b0, 1'b1);
		run_phase(1, 65535, 120, 1'b0, 1'b0);
		run_phase(65535, 1, 100, 1'b0, 1'b0);
		run_phase(65535, 65535, 80, 1'b0, 1'b0);
		run_phase(5, 30, 200, 1'b0, 1'b0);
		run_phase(50, 1000, 150, 1'b0, 1'b0);
		run_phase(4, 9, 150, 1'b0, 1'b0);
		settle();
		repeat (6) @(posedge clk);

		if (event_codes_due.size() != 0) begin
			$display("%0d predicted results never arrived", event_codes_due.size());
			mismatches += event_codes_due.size();
		end
		$display("Run covered %0d items with %0d reads checked across %0d register settings,",
			items_accepted, reads_checked, settings_used);
		$display("including %0d reads with a release flag and %0d with a hold flag.",
			release_events, hold_events);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
design/kdeg_pkg.sv
design/kdeg_in_stage.sv
design/kdeg_core.sv
design/kdeg_out_stage.sv
design/key_debounce_event_generator_top.sv
verif/key_debounce_event_generator_top_tb.sv
